/* src/bblc_pkg.sv */
// Shared types, constants and codes for the button and backlight controller.
package bblc_pkg;

  localparam int unsigned VERY_LONG_TICKS = 600;
  localparam int unsigned OFF_DELAY_MS    = 5000;
  localparam int unsigned LIGHT_BITS      = 12;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned PRESS_W  = 16;
  localparam int unsigned TIMER_W  = 13;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned DIV_STEPS = SAMPLE_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS + 1);

  localparam logic [SAMPLE_W-1:0] LIGHT_MASK =
    (LIGHT_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << LIGHT_BITS) - 1);
  localparam logic [PRESS_W-1:0]  PRESS_MAX  = {PRESS_W{1'b1}};
  localparam logic [PRESS_W-1:0]  VERY_LONG  = PRESS_W'(VERY_LONG_TICKS);
  localparam logic [TIMER_W-1:0]  OFF_DELAY  = TIMER_W'(OFF_DELAY_MS);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};

  // item kinds
  localparam logic [1:0] OP_BUTTON = 2'd0;
  localparam logic [1:0] OP_LIGHT  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_ALARM   = 3'd1;
  localparam logic [2:0] ACT_WOKEN   = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_ADDRESS = 3'd4;
  localparam logic [2:0] ACT_FACE    = 3'd5;
  localparam logic [2:0] ACT_MODE    = 3'd6;
  localparam logic [2:0] ACT_OFF     = 3'd7;

  // register indexes
  localparam logic [2:0] REG_SHORT   = 3'd0;
  localparam logic [2:0] REG_MEDIUM  = 3'd1;
  localparam logic [2:0] REG_LONG    = 3'd2;
  localparam logic [2:0] REG_HYST    = 3'd3;
  localparam logic [2:0] REG_DARK    = 3'd4;
  localparam logic [2:0] REG_DIVIDER = 3'd5;
  localparam logic [2:0] REG_FLOOR   = 3'd6;
  localparam logic [2:0] REG_CEILING = 3'd7;

  typedef struct packed {
    logic [1:0]          op;
    logic                button_down;
    logic                alarm_active;
    logic [SAMPLE_W-1:0] light_sample;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         beep_count;
    logic [LEVEL_W-1:0] backlight_level;
    logic               level_updated;
    logic               backlight_lit;
  } out_word_t;

  typedef struct packed {
    logic [9:0]          short_press_ticks;
    logic [9:0]          medium_press_ticks;
    logic [9:0]          long_press_ticks;
    logic [SAMPLE_W-1:0] light_hysteresis;
    logic [SAMPLE_W-1:0] dark_cutoff;
    logic [SAMPLE_W-1:0] light_divider;
    logic [LEVEL_W-1:0]  level_floor;
    logic [LEVEL_W-1:0]  level_ceiling;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic light_in;
  } sts_t;

endpackage

/* src/bblc_ctrl.sv */
// Sequencer: item capture, divider stepping and result hand-off.
module bblc_ctrl
  import bblc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  output logic result_valid,
  input  logic result_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t            state;
  logic [STEP_W-1:0] count;

  assign item_ready   = (state == S_IDLE);
  assign cmd.capture  = item_valid && item_ready;
  assign cmd.div_step = (state == S_DIV);
  assign cmd.commit   = (state == S_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.commit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            count <= '0;
            state <= sts.light_in ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == STEP_W'(DIV_STEPS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/bblc_dp.sv */
// Datapath: press counter, off timer, light divider, level clamp and result register.
module bblc_dp
  import bblc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_word_t  item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t result
);

  in_word_t            item_q;
  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W-1:0] rem;

  logic [PRESS_W-1:0]  press_length;
  logic [SAMPLE_W-1:0] last_light;
  logic                last_light_valid;
  logic                lit;
  logic [LEVEL_W-1:0]  level;
  logic [TIMER_W-1:0]  off_countdown;

  logic [PRESS_W-1:0]  press_length_next;
  logic [SAMPLE_W-1:0] last_light_next;
  logic                last_light_valid_next;
  logic                lit_next;
  logic [LEVEL_W-1:0]  level_next;
  logic [TIMER_W-1:0]  off_countdown_next;
  out_word_t           word_next;

  logic [SAMPLE_W-1:0] in_sample;
  logic [SAMPLE_W-1:0] dividend;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] diff;
  logic [PRESS_W-1:0]  press_inc;
  logic [LEVEL_W-1:0]  lvl;

  assign sts.light_in = (item.op == OP_LIGHT);

  // dark cutoff applied before the divider sees the reading
  assign in_sample = item.light_sample & LIGHT_MASK;
  assign dividend  = (in_sample < cfg.dark_cutoff) ? '0 : in_sample;
  assign trial     = {rem, quot[SAMPLE_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
      quot   <= dividend;
      rem    <= '0;
    end else if (cmd.div_step) begin
      // restoring division, one quotient bit a cycle
      if (trial >= {1'b0, cfg.light_divider}) begin
        rem  <= SAMPLE_W'(trial - {1'b0, cfg.light_divider});
        quot <= {quot[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem  <= trial[SAMPLE_W-1:0];
        quot <= {quot[SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  assign sample    = item_q.light_sample & LIGHT_MASK;
  assign diff      = (sample >= last_light) ? sample - last_light : last_light - sample;
  assign press_inc = press_length + 1'b1;

  always_comb begin
    press_length_next     = press_length;
    last_light_next       = last_light;
    last_light_valid_next = last_light_valid;
    lit_next              = lit;
    level_next            = level;
    off_countdown_next    = off_countdown;
    lvl                   = level;
    word_next             = '0;
    unique case (item_q.op)
      OP_BUTTON: begin
        if (item_q.button_down) begin
          if (press_length != PRESS_MAX) begin
            press_length_next = press_inc;
            priority if (press_inc == VERY_LONG)                     word_next.beep_count = 3'd4;
            else if (press_inc == PRESS_W'(cfg.long_press_ticks))   word_next.beep_count = 3'd3;
            else if (press_inc == PRESS_W'(cfg.medium_press_ticks)) word_next.beep_count = 3'd2;
            else if (press_inc == PRESS_W'(cfg.short_press_ticks))  word_next.beep_count = 3'd1;
            else                                                     word_next.beep_count = 3'd0;
          end
        end else if (press_length != '0) begin
          press_length_next = '0;
          priority if (item_q.alarm_active) word_next.action = ACT_ALARM;
          else if (!lit) begin
            lit_next              = 1'b1;
            last_light_valid_next = 1'b0;
            off_countdown_next    = OFF_DELAY;
            word_next.action      = ACT_WOKEN;
          end
          else if (press_length >= VERY_LONG)                     word_next.action = ACT_RESET;
          else if (press_length >= PRESS_W'(cfg.long_press_ticks))   word_next.action = ACT_ADDRESS;
          else if (press_length >= PRESS_W'(cfg.medium_press_ticks)) word_next.action = ACT_FACE;
          else if (press_length >= PRESS_W'(cfg.short_press_ticks))  word_next.action = ACT_MODE;
          else                                                       word_next.action = ACT_NONE;
        end
      end
      OP_LIGHT: begin
        if (lit && cfg.light_hysteresis != '0 &&
            (!last_light_valid || diff > cfg.light_hysteresis)) begin
          last_light_next       = sample;
          last_light_valid_next = 1'b1;
          if (cfg.light_divider != '0)
            lvl = (quot > SAMPLE_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[LEVEL_W-1:0];
          if (lvl < cfg.level_floor) lvl = cfg.level_floor;
          if (lvl > cfg.level_ceiling) lvl = cfg.level_ceiling;
          level_next              = lvl;
          word_next.level_updated = 1'b1;
        end
      end
      OP_TICK: begin
        if (off_countdown != '0) begin
          off_countdown_next = off_countdown - 1'b1;
          if (off_countdown == TIMER_W'(1)) begin
            lit_next         = 1'b0;
            word_next.action = ACT_OFF;
          end
        end
      end
      default: ;
    endcase
    word_next.backlight_level = level_next;
    word_next.backlight_lit   = lit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_length     <= '0;
      last_light       <= '0;
      last_light_valid <= 1'b0;
      lit              <= 1'b1;
      level            <= LEVEL_MAX;
      off_countdown    <= '0;
    end else if (cmd.commit) begin
      press_length     <= press_length_next;
      last_light       <= last_light_next;
      last_light_valid <= last_light_valid_next;
      lit              <= lit_next;
      level            <= level_next;
      off_countdown    <= off_countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) result <= word_next;
  end

endmodule

/* src/button_and_auto_backlight_control.sv */
// Button press timing and ambient-light backlight control, with its register port.
// Button and tick words go from capture to the done state, where the result is
// committed; light words first pass through the one-bit-a-cycle restoring divider.
// One word is held at a time: the next is taken once the current one is committed.
// A finished result waits in the output register while the next word is taken.
// Reset (rst, synchronous): registers to defaults, level 255, backlight lit, timer idle.
module button_and_auto_backlight_control
  import bblc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_word_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_press_ticks  <= 10'd5;
      cfg.medium_press_ticks <= 10'd100;
      cfg.long_press_ticks   <= 10'd300;
      cfg.light_hysteresis   <= 12'd50;
      cfg.dark_cutoff        <= 12'd0;
      cfg.light_divider      <= 12'd16;
      cfg.level_floor        <= 8'd0;
      cfg.level_ceiling      <= 8'd255;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SHORT:   cfg.short_press_ticks  <= pwdata[9:0];
        REG_MEDIUM:  cfg.medium_press_ticks <= pwdata[9:0];
        REG_LONG:    cfg.long_press_ticks   <= pwdata[9:0];
        REG_HYST:    cfg.light_hysteresis   <= pwdata[11:0];
        REG_DARK:    cfg.dark_cutoff        <= pwdata[11:0];
        REG_DIVIDER: cfg.light_divider      <= pwdata[11:0];
        REG_FLOOR:   cfg.level_floor        <= pwdata[7:0];
        REG_CEILING: cfg.level_ceiling      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHORT:   prdata = 32'(cfg.short_press_ticks);
      REG_MEDIUM:  prdata = 32'(cfg.medium_press_ticks);
      REG_LONG:    prdata = 32'(cfg.long_press_ticks);
      REG_HYST:    prdata = 32'(cfg.light_hysteresis);
      REG_DARK:    prdata = 32'(cfg.dark_cutoff);
      REG_DIVIDER: prdata = 32'(cfg.light_divider);
      REG_FLOOR:   prdata = 32'(cfg.level_floor);
      REG_CEILING: prdata = 32'(cfg.level_ceiling);
      default:     prdata = '0;
    endcase
  end

  bblc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  bblc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  // one word in flight: nothing is taken until the current one is committed
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("word accepted while another is in flight");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || result_ready))
    else $error("result register overwritten before hand-off");

  a_update_lit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.level_updated) |-> result.backlight_lit)
    else $error("level recomputed while backlight off");

  a_beep_no_action: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.beep_count == 3'd0 || result.action == ACT_NONE))
    else $error("beep and action in the same result");

endmodule

/* dv/bblc_checker.sv */
// Checker for the button and backlight controller: predicts each result word and compares it.
module bblc_checker
  import bblc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  in_word_t    item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);

  cfg_t                cfg;
  logic [PRESS_W-1:0]  press_len;
  logic [SAMPLE_W-1:0] last_light;
  logic                last_light_ok;
  logic                lit;
  logic [LEVEL_W-1:0]  level;
  logic [TIMER_W-1:0]  off_timer;
  out_word_t           due_results[$];

  task automatic advance_controller(input in_word_t w, output out_word_t r);
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] reading;
    logic [SAMPLE_W-1:0] quot;
    r = '0;
    s = w.light_sample & LIGHT_MASK;
    case (w.op)
      OP_BUTTON: begin
        if (w.button_down) begin
          // saturated press neither counts nor beeps
          if (press_len != PRESS_MAX) begin
            press_len = press_len + 1'b1;
            if (press_len == VERY_LONG) r.beep_count = 3'd4;
            else if (press_len == cfg.long_press_ticks) r.beep_count = 3'd3;
            else if (press_len == cfg.medium_press_ticks) r.beep_count = 3'd2;
            else if (press_len == cfg.short_press_ticks) r.beep_count = 3'd1;
          end
        end else if (press_len != '0) begin
          if (w.alarm_active) begin
            r.action = ACT_ALARM;
          end else if (!lit) begin
            lit = 1'b1;
            last_light_ok = 1'b0;
            off_timer = OFF_DELAY;
            r.action = ACT_WOKEN;
          end else if (press_len >= VERY_LONG) begin
            r.action = ACT_RESET;
          end else if (press_len >= cfg.long_press_ticks) begin
            r.action = ACT_ADDRESS;
          end else if (press_len >= cfg.medium_press_ticks) begin
            r.action = ACT_FACE;
          end else if (press_len >= cfg.short_press_ticks) begin
            r.action = ACT_MODE;
          end else begin
            r.action = ACT_NONE;
          end
          press_len = '0;
        end
      end
      OP_LIGHT: begin
        if (lit && cfg.light_hysteresis != '0) begin
          diff = (s >= last_light) ? s - last_light : last_light - s;
          if (!last_light_ok || diff > cfg.light_hysteresis) begin
            last_light = s;
            last_light_ok = 1'b1;
            reading = (s < cfg.dark_cutoff) ? '0 : s;
            if (cfg.light_divider != '0) begin
              quot = reading / cfg.light_divider;
              level = (quot > LEVEL_MAX) ? LEVEL_MAX : quot[LEVEL_W-1:0];
            end
            // floor first, so the ceiling wins when they cross
            if (level < cfg.level_floor) level = cfg.level_floor;
            if (level > cfg.level_ceiling) level = cfg.level_ceiling;
            r.level_updated = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (off_timer != '0) begin
          off_timer = off_timer - 1'b1;
          if (off_timer == '0) begin
            lit = 1'b0;
            r.action = ACT_OFF;
          end
        end
      end
      default: ;
    endcase
    r.backlight_level = level;
    r.backlight_lit = lit;
  endtask

  task automatic compare_result(input out_word_t got, input out_word_t want);
    if (got.action !== want.action) begin
      $error("action: expected %0d, got %0d", want.action, got.action);
      fail_count++;
    end
    if (got.beep_count !== want.beep_count) begin
      $error("beep_count: expected %0d, got %0d", want.beep_count, got.beep_count);
      fail_count++;
    end
    if (got.backlight_level !== want.backlight_level) begin
      $error("backlight_level: expected %0d, got %0d", want.backlight_level,
             got.backlight_level);
      fail_count++;
    end
    if (got.level_updated !== want.level_updated) begin
      $error("level_updated: expected %0d, got %0d", want.level_updated, got.level_updated);
      fail_count++;
    end
    if (got.backlight_lit !== want.backlight_lit) begin
      $error("backlight_lit: expected %0d, got %0d", want.backlight_lit, got.backlight_lit);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      cfg = '{short_press_ticks: 10'd5, medium_press_ticks: 10'd100,
              long_press_ticks: 10'd300, light_hysteresis: 12'd50, dark_cutoff: '0,
              light_divider: 12'd16, level_floor: '0, level_ceiling: LEVEL_MAX};
      press_len = '0;
      last_light = '0;
      last_light_ok = 1'b0;
      lit = 1'b1;
      level = LEVEL_MAX;
      off_timer = '0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SHORT:   cfg.short_press_ticks = pwdata[9:0];
          REG_MEDIUM:  cfg.medium_press_ticks = pwdata[9:0];
          REG_LONG:    cfg.long_press_ticks = pwdata[9:0];
          REG_HYST:    cfg.light_hysteresis = pwdata[SAMPLE_W-1:0];
          REG_DARK:    cfg.dark_cutoff = pwdata[SAMPLE_W-1:0];
          REG_DIVIDER: cfg.light_divider = pwdata[SAMPLE_W-1:0];
          REG_FLOOR:   cfg.level_floor = pwdata[LEVEL_W-1:0];
          REG_CEILING: cfg.level_ceiling = pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
      // pop before push, so a stray result cannot match the word taken this edge
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          compare_result(result, due_results.pop_front());
        end
      end
      if (item_valid && item_ready) begin
        advance_controller(item, want);
        due_results.push_back(want);
      end
    end
    pending_count <= due_results.size();
  end

endmodule

/* dv/tb_button_and_auto_backlight_control.sv */
// Testbench top for the button and backlight controller: stimulus, register writes and verdict.
module tb_button_and_auto_backlight_control;
  import bblc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned WORDS_PER_SETUP = 60;
  localparam logic [1:0]  OP_UNUSED       = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_word_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_word_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending_count;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  cfg_t        cfg_shadow;
  logic [SAMPLE_W-1:0] prev_light = '0;

  button_and_auto_backlight_control dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bblc_checker checker_i (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_word_t make_word(input logic [1:0] op);
    in_word_t w;
    w.op = op;
    w.button_down = 1'($urandom_range(1));
    w.alarm_active = 1'($urandom_range(1));
    w.light_sample = SAMPLE_W'($urandom_range(4095));
    return w;
  endfunction

  // valid is only dropped when a gap is taken, never lowered and raised in one step
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_light(input logic [SAMPLE_W-1:0] s);
    in_word_t w;
    w = make_word(OP_LIGHT);
    w.light_sample = s;
    send_word(w);
    prev_light = s;
  endtask

  task automatic hold_and_release(input int unsigned len, input logic alarm, input bit mixed);
    in_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      if (mixed && $urandom_range(9) == 0)
        send_word(make_word($urandom_range(1) ? OP_LIGHT : OP_TICK));
      w = make_word(OP_BUTTON);
      w.button_down = 1'b1;
      send_word(w);
    end
    w = make_word(OP_BUTTON);
    w.button_down = 1'b0;
    w.alarm_active = alarm;
    send_word(w);
  endtask

  task automatic quiesce();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SHORT:   cfg_shadow.short_press_ticks = value[9:0];
      REG_MEDIUM:  cfg_shadow.medium_press_ticks = value[9:0];
      REG_LONG:    cfg_shadow.long_press_ticks = value[9:0];
      REG_HYST:    cfg_shadow.light_hysteresis = value[SAMPLE_W-1:0];
      REG_DARK:    cfg_shadow.dark_cutoff = value[SAMPLE_W-1:0];
      REG_DIVIDER: cfg_shadow.light_divider = value[SAMPLE_W-1:0];
      REG_FLOOR:   cfg_shadow.level_floor = value[LEVEL_W-1:0];
      REG_CEILING: cfg_shadow.level_ceiling = value[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_setting(input int unsigned lo, hi, typ);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(typ, lo);
    endcase
  endfunction

  task automatic program_random_config();
    write_reg(REG_SHORT, pick_setting(1, 1023, 8));
    write_reg(REG_MEDIUM, pick_setting(1, 1023, 24));
    write_reg(REG_LONG, pick_setting(1, 1023, 48));
    write_reg(REG_HYST, pick_setting(0, 4095, 300));
    write_reg(REG_DARK, pick_setting(0, 4095, 800));
    write_reg(REG_DIVIDER, pick_setting(0, 4095, 40));
    write_reg(REG_FLOOR, pick_setting(0, 255, 255));
    write_reg(REG_CEILING, pick_setting(0, 255, 255));
  endtask

  // lengths cluster on the thresholds; thresholds out of reach fall back to short presses
  function automatic int unsigned pick_press_len();
    int unsigned n;
    case ($urandom_range(4))
      0: n = 32'(cfg_shadow.short_press_ticks);
      1: n = 32'(cfg_shadow.medium_press_ticks);
      2: n = 32'(cfg_shadow.long_press_ticks);
      default: n = $urandom_range(30, 1);
    endcase
    n = n + $urandom_range(2) - 1;
    if (n > 64) n = $urandom_range(64, 1);
    return n;
  endfunction

  // with hysteresis up to 300, half the readings sit near the last one, either side of the hysteresis band
  function automatic logic [SAMPLE_W-1:0] pick_light();
    int h;
    int v;
    h = int'(cfg_shadow.light_hysteresis);
    if (h > 300 || $urandom_range(1)) return SAMPLE_W'($urandom_range(4095));
    v = int'(prev_light) + int'($urandom_range(2 * h + 4)) - h - 2;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic random_traffic(input int unsigned words);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    sent = 0;
    while (sent < words) begin
      roll = $urandom_range(19);
      if (roll < 10) begin
        len = pick_press_len();
        hold_and_release(len, $urandom_range(3) == 0, 1'b1);
        sent += len + 1;
      end else if (roll < 16) begin
        send_light(pick_light());
        sent++;
      end else if (roll < 19) begin
        send_word(make_word(OP_TICK));
        sent++;
      end else begin
        send_word(make_word(OP_UNUSED));
      end
    end
  endtask

  initial begin
    cfg_shadow = '{short_press_ticks: 10'd5, medium_press_ticks: 10'd100,
                   long_press_ticks: 10'd300, light_hysteresis: 12'd50, dark_cutoff: '0,
                   light_divider: 12'd16, level_floor: '0, level_ceiling: LEVEL_MAX};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset settings
    send_word(make_word(OP_TICK));
    send_word(make_word(OP_UNUSED));
    hold_and_release(0, 1'b0, 1'b0);
    send_light(12'hFFF);
    send_light(12'h000);
    send_light(12'd30);
    send_light(12'd81);
    hold_and_release(5, 1'b0, 1'b0);
    hold_and_release(2, 1'b0, 1'b0);
    hold_and_release(3, 1'b1, 1'b0);

    // all thresholds equal: long beep wins
    quiesce();
    write_reg(REG_SHORT, 3);
    write_reg(REG_MEDIUM, 3);
    write_reg(REG_LONG, 3);
    hold_and_release(3, 1'b0, 1'b0);

    // long on the very-long mark: very-long beep, then the reset action
    quiesce();
    write_reg(REG_SHORT, 1);
    write_reg(REG_MEDIUM, 2);
    write_reg(REG_LONG, VERY_LONG_TICKS);
    hold_and_release(VERY_LONG_TICKS + 1, 1'b0, 1'b0);

    quiesce();
    write_reg(REG_HYST, 0);
    send_light(12'd2000);

    // dark cutoff at top, floor above ceiling
    quiesce();
    write_reg(REG_HYST, 1);
    write_reg(REG_DARK, 4095);
    write_reg(REG_DIVIDER, 1);
    write_reg(REG_FLOOR, 200);
    write_reg(REG_CEILING, 100);
    send_light(12'd4094);
    send_light(12'd100);

    quiesce();
    write_reg(REG_DARK, 0);
    write_reg(REG_FLOOR, 0);
    write_reg(REG_CEILING, 255);
    send_light(12'hFFF);

    quiesce();
    write_reg(REG_DIVIDER, 0);
    send_light(12'd10);

    quiesce();
    write_reg(REG_DIVIDER, 4095);
    send_light(12'hFFF);

    for (int phase = 0; phase < 3; phase++) begin
      quiesce();
      case (phase)
        0: begin
          send_idle = 6;
          recv_idle <= 70;
        end
        1: begin
          send_idle = 70;
          recv_idle <= 6;
        end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
        end
      endcase
      for (int setup = 0; setup < 2; setup++) begin
        quiesce();
        program_random_config();
        random_traffic(WORDS_PER_SETUP);
      end
    end

    quiesce();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* button_and_auto_backlight_control.f */
src/bblc_pkg.sv
src/bblc_ctrl.sv
src/bblc_dp.sv
src/button_and_auto_backlight_control.sv
dv/bblc_checker.sv
dv/tb_button_and_auto_backlight_control.sv
